FILE: hdl/euler_rotate_perspective_project_defines.svh
// Assertion helpers used by the block's top-level RTL.
`ifndef EULER_ROTATE_PERSPECTIVE_PROJECT_DEFINES_SVH
`define EULER_ROTATE_PERSPECTIVE_PROJECT_DEFINES_SVH

// Same-cycle implication, sampled on the block clock.
`define ERPP_ASSERT_IMP(label, rst, ante, cons) \
   label: assert property (@(posedge clock) disable iff (rst) (ante) |-> (cons)) \
      else $error("erpp same-cycle check failed");

// Next-cycle implication, sampled on the block clock.
`define ERPP_ASSERT_NXT(label, rst, ante, cons) \
   label: assert property (@(posedge clock) disable iff (rst) (ante) |=> (cons)) \
      else $error("erpp next-cycle check failed");

`endif

FILE: hdl/erpp_pkg.sv
`default_nettype none

package erpp_pkg;

   localparam int COORD_W    = 32;
   localparam int TRIG_W     = 16;
   localparam int TRIG_FRAC  = 14;
   localparam int MAT_W      = 17;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int PROD_W     = DIFF_W + MAT_W;
   localparam int ACC_W      = PROD_W + 2;
   localparam int CSR_ADDR_W = 3;
   localparam int DIV_STEPS  = 16;
   localparam int NUM_W      = COORD_W + 9;
   localparam int ZPROD_W    = COORD_W + MAT_W;
   localparam int REM_W      = COORD_W - 1 + DIV_STEPS;

   typedef logic signed [TRIG_W-1:0] trig_type;
   typedef logic signed [MAT_W-1:0]  mat_type;

   localparam trig_type TRIG_ONE = 16'sd16384;
   localparam logic signed [ACC_W-1:0] ACC_ROUND = 52'sd1 <<< (TRIG_FRAC - 1);

   localparam logic signed [NUM_W-1:0] SCREEN_SCALE = 41'sd400;
   // Bounds (-32768 - offset) and (32768 - offset) for each pixel axis.
   localparam mat_type LOW_X  = -17'sd33168;
   localparam mat_type HIGH_X = 17'sd32368;
   localparam mat_type LOW_Y  = -17'sd33068;
   localparam mat_type HIGH_Y = 17'sd32468;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_ANGLE_X  = 3'd0,
      REG_ANGLE_Y  = 3'd1,
      REG_ANGLE_Z  = 3'd2,
      REG_CENTER_X = 3'd3,
      REG_CENTER_Y = 3'd4,
      REG_CENTER_Z = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] z;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } vec_type;

   typedef struct packed {
      mat_type m00, m01, m02;
      mat_type m10, m11, m12;
      mat_type m20, m21, m22;
      logic signed [COORD_W-1:0] cx, cy, cz;
   } coef_type;

   // sin(d) in Q1.14 for whole degrees 0..90, rounded half up.
   localparam logic [14:0] SIN_TABLE [0:90] = '{
      15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
      15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
      15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
      15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
      15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
      15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
      15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
      15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
      15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
      15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
      15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
      15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
      15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
   };

   // Sine of an angle below 720 degrees; fold by quadrant onto the table.
   function automatic trig_type trig_of(input logic [9:0] deg);
      logic [9:0]  d;
      logic [9:0]  fold;
      logic        neg;
      logic [15:0] mag;
      d   = (deg >= 10'd360) ? deg - 10'd360 : deg;
      neg = 1'b0;
      priority if (d <= 10'd90) begin
         fold = d;
      end else if (d <= 10'd180) begin
         fold = 10'd180 - d;
      end else if (d <= 10'd270) begin
         fold = d - 10'd180;
         neg  = 1'b1;
      end else begin
         fold = 10'd360 - d;
         neg  = 1'b1;
      end
      mag = {1'b0, SIN_TABLE[fold[6:0]]};
      return neg ? trig_type'(-mag) : trig_type'(mag);
   endfunction

   // Rounded Q1.14 product.
   function automatic trig_type tmul(input trig_type a, input trig_type b);
      logic signed [31:0] p;
      p = 32'(a) * 32'(b) + (32'sd1 <<< (TRIG_FRAC - 1));
      return p[TRIG_FRAC+TRIG_W-1:TRIG_FRAC];
   endfunction

endpackage

`default_nettype wire

FILE: hdl/erpp_coef.sv
`default_nettype none

module erpp_coef (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [erpp_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  wire logic [erpp_pkg::COORD_W-1:0]        csr_wdata,
   output erpp_pkg::coef_type                       coef
);

   erpp_pkg::trig_type sx_ff, sx_in, cx_ff, cx_in;
   erpp_pkg::trig_type sy_ff, sy_in, cy_ff, cy_in;
   erpp_pkg::trig_type sz_ff, sz_in, cz_ff, cz_in;
   logic signed [erpp_pkg::COORD_W-1:0] cenx_ff, cenx_in, ceny_ff, ceny_in, cenz_ff, cenz_in;

   erpp_pkg::trig_type sxsy_ff, cxsy_ff, cycz_ff, cxsz_ff, sxsz_ff;
   erpp_pkg::trig_type cysz_ff, cxcz_ff, sxcz_ff, sxcy_ff, cxcy_ff;
   erpp_pkg::mat_type  m00_ff, m01_ff, m02_ff, m10_ff, m11_ff, m12_ff, m20_ff, m21_ff, m22_ff;

   erpp_pkg::trig_type wr_sin, wr_cos;

   // Angle writes store sine and cosine straight away.
   always_comb begin
      wr_sin  = erpp_pkg::trig_of({1'b0, csr_wdata[8:0]});
      wr_cos  = erpp_pkg::trig_of(10'(csr_wdata[8:0]) + 10'd90);
      sx_in   = sx_ff;
      cx_in   = cx_ff;
      sy_in   = sy_ff;
      cy_in   = cy_ff;
      sz_in   = sz_ff;
      cz_in   = cz_ff;
      cenx_in = cenx_ff;
      ceny_in = ceny_ff;
      cenz_in = cenz_ff;
      if (csr_we) begin
         unique case (erpp_pkg::reg_index_type'(csr_addr))
            erpp_pkg::REG_ANGLE_X: begin
               sx_in = wr_sin;
               cx_in = wr_cos;
            end
            erpp_pkg::REG_ANGLE_Y: begin
               sy_in = wr_sin;
               cy_in = wr_cos;
            end
            erpp_pkg::REG_ANGLE_Z: begin
               sz_in = wr_sin;
               cz_in = wr_cos;
            end
            erpp_pkg::REG_CENTER_X: cenx_in = csr_wdata;
            erpp_pkg::REG_CENTER_Y: ceny_in = csr_wdata;
            erpp_pkg::REG_CENTER_Z: cenz_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sx_ff   <= '0;
         sy_ff   <= '0;
         sz_ff   <= '0;
         cx_ff   <= erpp_pkg::TRIG_ONE;
         cy_ff   <= erpp_pkg::TRIG_ONE;
         cz_ff   <= erpp_pkg::TRIG_ONE;
         cenx_ff <= '0;
         ceny_ff <= '0;
         cenz_ff <= '0;
      end else begin
         sx_ff   <= sx_in;
         sy_ff   <= sy_in;
         sz_ff   <= sz_in;
         cx_ff   <= cx_in;
         cy_ff   <= cy_in;
         cz_ff   <= cz_in;
         cenx_ff <= cenx_in;
         ceny_ff <= ceny_in;
         cenz_ff <= cenz_in;
      end
   end

   // Two-factor terms are registered, then three-factor terms and sums are registered into the matrix.
   always_ff @(posedge clock) begin
      sxsy_ff <= erpp_pkg::tmul(sx_ff, sy_ff);
      cxsy_ff <= erpp_pkg::tmul(cx_ff, sy_ff);
      cycz_ff <= erpp_pkg::tmul(cy_ff, cz_ff);
      cxsz_ff <= erpp_pkg::tmul(cx_ff, sz_ff);
      sxsz_ff <= erpp_pkg::tmul(sx_ff, sz_ff);
      cysz_ff <= erpp_pkg::tmul(cy_ff, sz_ff);
      cxcz_ff <= erpp_pkg::tmul(cx_ff, cz_ff);
      sxcz_ff <= erpp_pkg::tmul(sx_ff, cz_ff);
      sxcy_ff <= erpp_pkg::tmul(sx_ff, cy_ff);
      cxcy_ff <= erpp_pkg::tmul(cx_ff, cy_ff);
   end

   always_ff @(posedge clock) begin
      m00_ff <= 17'(cycz_ff);
      m01_ff <= 17'(erpp_pkg::tmul(sxsy_ff, cz_ff)) - 17'(cxsz_ff);
      m02_ff <= 17'(sxsz_ff) + 17'(erpp_pkg::tmul(cxsy_ff, cz_ff));
      m10_ff <= 17'(cysz_ff);
      m11_ff <= 17'(cxcz_ff) + 17'(erpp_pkg::tmul(sxsy_ff, sz_ff));
      m12_ff <= 17'(erpp_pkg::tmul(cxsy_ff, sz_ff)) - 17'(sxcz_ff);
      m20_ff <= -17'(sy_ff);
      m21_ff <= 17'(sxcy_ff);
      m22_ff <= 17'(cxcy_ff);
   end

   always_comb begin
      coef.m00 = m00_ff;
      coef.m01 = m01_ff;
      coef.m02 = m02_ff;
      coef.m10 = m10_ff;
      coef.m11 = m11_ff;
      coef.m12 = m12_ff;
      coef.m20 = m20_ff;
      coef.m21 = m21_ff;
      coef.m22 = m22_ff;
      coef.cx  = cenx_ff;
      coef.cy  = ceny_ff;
      coef.cz  = cenz_ff;
   end

endmodule

`default_nettype wire

FILE: hdl/erpp_rot.sv
`default_nettype none

module erpp_rot (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire erpp_pkg::vec_type    in_vtx,
   input  wire erpp_pkg::coef_type   coef,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output erpp_pkg::vec_type         out_rot
);

   logic v0_ff, v1_ff, v2_ff, v3_ff, v4_ff;
   logic ld0, ld1, ld2, ld3, ld4;

   erpp_pkg::vec_type vtx_ff;
   logic signed [erpp_pkg::DIFF_W-1:0] diff_ff [3];
   logic signed [erpp_pkg::DIFF_W-1:0] diff_in [3];
   logic signed [erpp_pkg::PROD_W-1:0] prod_ff [9];
   logic signed [erpp_pkg::PROD_W-1:0] prod_in [9];
   logic signed [erpp_pkg::ACC_W-1:0]  acc_ff [3];
   logic signed [erpp_pkg::ACC_W-1:0]  acc_in [3];
   erpp_pkg::vec_type rot_ff, rot_in;
   erpp_pkg::mat_type m [9];

   // A stage loads when empty or when the stage after it moves on.
   assign ld4      = !v4_ff || out_ready;
   assign ld3      = !v3_ff || ld4;
   assign ld2      = !v2_ff || ld3;
   assign ld1      = !v1_ff || ld2;
   assign ld0      = !v0_ff || ld1;
   assign in_ready = ld0 && !reset;

   assign m[0] = coef.m00;
   assign m[1] = coef.m01;
   assign m[2] = coef.m02;
   assign m[3] = coef.m10;
   assign m[4] = coef.m11;
   assign m[5] = coef.m12;
   assign m[6] = coef.m20;
   assign m[7] = coef.m21;
   assign m[8] = coef.m22;

   always_comb begin
      diff_in[0] = erpp_pkg::DIFF_W'(vtx_ff.x) - erpp_pkg::DIFF_W'(coef.cx);
      diff_in[1] = erpp_pkg::DIFF_W'(vtx_ff.y) - erpp_pkg::DIFF_W'(coef.cy);
      diff_in[2] = erpp_pkg::DIFF_W'(vtx_ff.z) - erpp_pkg::DIFF_W'(coef.cz);
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[r*3+c] = erpp_pkg::PROD_W'(diff_ff[c]) * erpp_pkg::PROD_W'(m[r*3+c]);
         end
         acc_in[r] = erpp_pkg::ACC_W'(prod_ff[r*3]) + erpp_pkg::ACC_W'(prod_ff[r*3+1])
                   + erpp_pkg::ACC_W'(prod_ff[r*3+2]) + erpp_pkg::ACC_ROUND;
      end
      rot_in.x = acc_ff[0][erpp_pkg::TRIG_FRAC+erpp_pkg::COORD_W-1:erpp_pkg::TRIG_FRAC]
               + coef.cx;
      rot_in.y = acc_ff[1][erpp_pkg::TRIG_FRAC+erpp_pkg::COORD_W-1:erpp_pkg::TRIG_FRAC]
               + coef.cy;
      rot_in.z = acc_ff[2][erpp_pkg::TRIG_FRAC+erpp_pkg::COORD_W-1:erpp_pkg::TRIG_FRAC]
               + coef.cz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (ld0) v0_ff <= in_valid;
         if (ld1) v1_ff <= v0_ff;
         if (ld2) v2_ff <= v1_ff;
         if (ld3) v3_ff <= v2_ff;
         if (ld4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld0) vtx_ff <= in_vtx;
      if (ld1) diff_ff <= diff_in;
      if (ld2) prod_ff <= prod_in;
      if (ld3) acc_ff <= acc_in;
      if (ld4) rot_ff <= rot_in;
   end

   assign out_valid = v4_ff;
   assign out_rot   = rot_ff;

endmodule

`default_nettype wire

FILE: hdl/erpp_proj.sv
`default_nettype none

module erpp_proj (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire erpp_pkg::vec_type   in_rot,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output erpp_pkg::vec_type        out_rot,
   output logic [15:0]              out_screen_x,
   output logic [15:0]              out_screen_y,
   output logic                     out_behind,
   output logic                     out_sat
);

   typedef struct packed {
      erpp_pkg::vec_type                      rot;
      logic                                   behind;
      logic signed [erpp_pkg::NUM_W-1:0]      nx, ny;
      logic signed [erpp_pkg::ZPROD_W-1:0]    lzx, hzx, lzy, hzy;
   } pm_type;

   typedef struct packed {
      erpp_pkg::vec_type                      rot;
      logic                                   behind;
      logic                                   lox, hix, loy, hiy;
      logic [erpp_pkg::COORD_W-2:0]           zpos;
      logic [erpp_pkg::REM_W-1:0]             remx, remy;
      logic [erpp_pkg::DIV_STEPS-1:0]         qx, qy;
   } div_type;

   localparam int NS = erpp_pkg::DIV_STEPS;

   pm_type  pm_ff, pm_in;
   logic    vpm_ff, ldpm;
   div_type st_ff [0:NS];
   div_type st_in [0:NS];
   logic    vst_ff [0:NS];
   logic    ldst [0:NS];
   logic    vout_ff, ldout;

   erpp_pkg::vec_type rot_ff;
   logic [15:0]       sx_ff, sy_ff, sx_in, sy_in;
   logic              behind_ff, sat_ff, sat_in;

   logic signed [erpp_pkg::ZPROD_W-1:0] nxw, nyw;

   assign ldout    = !vout_ff || out_ready;
   assign ldst[NS] = !vst_ff[NS] || ldout;
   assign ldpm     = !vpm_ff || ldst[0];
   assign in_ready = ldpm;

   // Numerators and the clamp bounds scaled by z.
   always_comb begin
      pm_in.rot    = in_rot;
      pm_in.behind = in_rot.z[erpp_pkg::COORD_W-1] || (in_rot.z == '0);
      pm_in.nx     = erpp_pkg::NUM_W'(in_rot.x) * erpp_pkg::SCREEN_SCALE;
      pm_in.ny     = erpp_pkg::NUM_W'(in_rot.y) * erpp_pkg::SCREEN_SCALE;
      pm_in.lzx    = erpp_pkg::ZPROD_W'(in_rot.z) * erpp_pkg::ZPROD_W'(erpp_pkg::LOW_X);
      pm_in.hzx    = erpp_pkg::ZPROD_W'(in_rot.z) * erpp_pkg::ZPROD_W'(erpp_pkg::HIGH_X);
      pm_in.lzy    = erpp_pkg::ZPROD_W'(in_rot.z) * erpp_pkg::ZPROD_W'(erpp_pkg::LOW_Y);
      pm_in.hzy    = erpp_pkg::ZPROD_W'(in_rot.z) * erpp_pkg::ZPROD_W'(erpp_pkg::HIGH_Y);
   end

   // Clamp tests, and the offset remainder that the divider works down.
   always_comb begin
      nxw             = erpp_pkg::ZPROD_W'(pm_ff.nx);
      nyw             = erpp_pkg::ZPROD_W'(pm_ff.ny);
      st_in[0].rot    = pm_ff.rot;
      st_in[0].behind = pm_ff.behind;
      st_in[0].lox    = nxw < pm_ff.lzx;
      st_in[0].hix    = !(nxw < pm_ff.hzx);
      st_in[0].loy    = nyw < pm_ff.lzy;
      st_in[0].hiy    = !(nyw < pm_ff.hzy);
      st_in[0].zpos   = pm_ff.rot.z[erpp_pkg::COORD_W-2:0];
      st_in[0].remx   = erpp_pkg::REM_W'(nxw - pm_ff.lzx);
      st_in[0].remy   = erpp_pkg::REM_W'(nyw - pm_ff.lzy);
      st_in[0].qx     = '0;
      st_in[0].qy     = '0;
   end

   for (genvar k = 0; k < NS; k++) begin : g_div
      localparam int B = NS - 1 - k;
      logic [erpp_pkg::REM_W-1:0] t;

      assign ldst[k] = !vst_ff[k] || ldst[k+1];

      // One quotient bit per stage for each axis.
      always_comb begin
         t          = erpp_pkg::REM_W'(st_ff[k].zpos) << B;
         st_in[k+1] = st_ff[k];
         if (st_ff[k].remx >= t) begin
            st_in[k+1].remx  = st_ff[k].remx - t;
            st_in[k+1].qx[B] = 1'b1;
         end
         if (st_ff[k].remy >= t) begin
            st_in[k+1].remy  = st_ff[k].remy - t;
            st_in[k+1].qy[B] = 1'b1;
         end
      end
   end

   always_comb begin
      priority if (st_ff[NS].lox) begin
         sx_in = 16'h8000;
      end else if (st_ff[NS].hix) begin
         sx_in = 16'h7FFF;
      end else begin
         sx_in = st_ff[NS].qx ^ 16'h8000;
      end
      priority if (st_ff[NS].loy) begin
         sy_in = 16'h8000;
      end else if (st_ff[NS].hiy) begin
         sy_in = 16'h7FFF;
      end else begin
         sy_in = st_ff[NS].qy ^ 16'h8000;
      end
      sat_in = st_ff[NS].lox || st_ff[NS].hix || st_ff[NS].loy || st_ff[NS].hiy;
      // Drop the pixels when the vertex sits behind the camera.
      if (st_ff[NS].behind) begin
         sx_in  = '0;
         sy_in  = '0;
         sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vpm_ff  <= 1'b0;
         vout_ff <= 1'b0;
         for (int i = 0; i <= NS; i++) vst_ff[i] <= 1'b0;
      end else begin
         if (ldpm) vpm_ff <= in_valid;
         if (ldst[0]) vst_ff[0] <= vpm_ff;
         for (int i = 1; i <= NS; i++) begin
            if (ldst[i]) vst_ff[i] <= vst_ff[i-1];
         end
         if (ldout) vout_ff <= vst_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (ldpm) pm_ff <= pm_in;
      for (int i = 0; i <= NS; i++) begin
         if (ldst[i]) st_ff[i] <= st_in[i];
      end
      if (ldout) begin
         rot_ff    <= st_ff[NS].rot;
         behind_ff <= st_ff[NS].behind;
         sx_ff     <= sx_in;
         sy_ff     <= sy_in;
         sat_ff    <= sat_in;
      end
   end

   assign out_valid    = vout_ff;
   assign out_rot      = rot_ff;
   assign out_screen_x = sx_ff;
   assign out_screen_y = sy_ff;
   assign out_behind   = behind_ff;
   assign out_sat      = sat_ff;

endmodule

`default_nettype wire

FILE: hdl/euler_rotate_perspective_project.sv
// Vertex transform: Euler rotation about a centre, then perspective projection.
// Configuration: write csr_wdata to register csr_addr while csr_we is high
// (0..2 angles X/Y/Z in degrees, 3..5 centre X/Y/Z in Q16.16); other indexes
// are dropped. Sine and cosine are latched on the write; the rotation matrix
// then settles through the pairwise-product and matrix registers, ahead of any vertex that follows.
// Input: one vertex per req_ transaction, X/Y/Z in Q16.16.
// Output: one rsp_ transaction per vertex: the rotated vertex, the pixel
// column and row (400*x/z + 400, 400*y/z + 300, clamped to 16 bits) and flags.
// The pipe holds the rotation stages (input register, centre subtract,
// matrix multiply, sum, centre add), the projection set-up registers,
// sixteen restoring divider steps (one quotient bit each) and the output
// register. Throughput is one vertex per cycle while rsp_tready stays high.
// A stalled receiver holds the output register; stages behind it keep
// filling bubbles, so req_tready drops only once the whole pipe is full.
// Synchronous reset empties the pipe, sets angles and centre to zero, and
// holds req_tready low while asserted.
`default_nettype none
`include "euler_rotate_perspective_project_defines.svh"

module euler_rotate_perspective_project (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [95:0]                       req_tdata,  // vertex_x, vertex_y, vertex_z
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // rotated_x, rotated_y, rotated_z, screen_x, screen_y
   output logic [127:0]                           rsp_tdata,
   output logic [1:0]                             rsp_tuser,  // behind_camera, pixel_saturated
   input  wire logic                              csr_we,
   input  wire logic [erpp_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire logic [erpp_pkg::COORD_W-1:0]      csr_wdata
);

   erpp_pkg::coef_type coef;
   erpp_pkg::vec_type  in_vtx, mid_rot, out_rot;
   logic               mid_valid, mid_ready;
   logic [15:0]        screen_x, screen_y;
   logic               behind, sat;

   assign in_vtx.x = req_tdata[31:0];
   assign in_vtx.y = req_tdata[63:32];
   assign in_vtx.z = req_tdata[95:64];

   erpp_coef u_coef (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .coef      (coef)
   );

   erpp_rot u_rot (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_vtx    (in_vtx),
      .coef      (coef),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_rot   (mid_rot)
   );

   erpp_proj u_proj (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (mid_valid),
      .in_ready     (mid_ready),
      .in_rot       (mid_rot),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_rot      (out_rot),
      .out_screen_x (screen_x),
      .out_screen_y (screen_y),
      .out_behind   (behind),
      .out_sat      (sat)
   );

   assign rsp_tdata = {screen_y, screen_x, out_rot.z, out_rot.y, out_rot.x};
   assign rsp_tuser = {sat, behind};

   `ERPP_ASSERT_IMP(a_behind_matches_z, reset, rsp_tvalid, behind == (out_rot.z <= 0))
   `ERPP_ASSERT_IMP(a_behind_no_pixels, reset, rsp_tvalid && behind, (screen_x == '0) && (screen_y == '0) && !sat)
   `ERPP_ASSERT_NXT(a_reset_empties, 1'b0, reset, !rsp_tvalid)
   `ERPP_ASSERT_IMP(a_reset_holds_input, 1'b0, reset, !req_tready)

endmodule

`default_nettype wire

FILE: sim/euler_rotate_perspective_project_test.sv
`default_nettype none

module euler_rotate_perspective_project_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [erpp_pkg::CSR_ADDR_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [erpp_pkg::CSR_ADDR_W-1:0] REG_SPARE_HI = 3'd7;
   localparam longint unsigned PI_Q60 = 64'h3243F6A8885A308D;
   localparam longint unsigned RAD_PER_DEG = PI_Q60 / 180;
   localparam int FRAC = 14;
   localparam int TAIL_CYCLES = 40;
   localparam int STALL_LIMIT = 5000;

   typedef struct {
      logic [31:0] x, y, z;
   } vertex_type;

   typedef struct {
      logic [31:0] rot_x, rot_y, rot_z;
      logic [15:0] pix_x, pix_y;
      logic        behind, sat;
   } projection_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [95:0] req_tdata = '0;         // vertex_x, vertex_y, vertex_z
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;             // rotated_x, rotated_y, rotated_z, screen_x, screen_y
   logic [1:0] rsp_tuser;               // behind_camera, pixel_saturated
   logic csr_we = 1'b0;
   logic [erpp_pkg::CSR_ADDR_W-1:0] csr_addr = '0;
   logic [erpp_pkg::COORD_W-1:0] csr_wdata = '0;

   euler_rotate_perspective_project u_dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_we, .csr_addr, .csr_wdata
   );

   // shadow copy of the register file
   int unsigned angle_x, angle_y, angle_z;
   longint      centre_x, centre_y, centre_z;

   vertex_type     pending_vertices[$];
   projection_type expected_projections[$];
   int             failures = 0;
   int             idle_pct = 12;
   int             quiet_cycles = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic longint unsigned q60_mul(longint unsigned a, longint unsigned b);
      logic [127:0] w;
      w = {64'd0, a} * {64'd0, b};
      return w[123:60];
   endfunction

   function automatic longint unsigned sine_q60(int unsigned d);
      longint unsigned x, x2, term, sum;
      x = RAD_PER_DEG * d;
      x2 = q60_mul(x, x);
      term = x;
      sum = x;
      for (int n = 1; n <= 40 && term != 0; n++) begin
         term = q60_mul(term, x2) / longint'((2 * n) * (2 * n + 1));
         sum = (n % 2 == 1) ? sum - term : sum + term;
      end
      return sum;
   endfunction

   function automatic longint sine_fixed(int unsigned deg);
      longint unsigned s, r;
      bit neg;
      neg = 0;
      deg = deg % 360;
      if (deg <= 90) s = sine_q60(deg);
      else if (deg <= 180) s = sine_q60(180 - deg);
      else if (deg <= 270) begin
         s = sine_q60(deg - 180);
         neg = 1;
      end else begin
         s = sine_q60(360 - deg);
         neg = 1;
      end
      r = (s + (64'd1 << (59 - FRAC))) >> (60 - FRAC);
      return neg ? -longint'(r) : longint'(r);
   endfunction

   function automatic longint trig_mul(longint a, longint b);
      return (a * b + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
   endfunction

   // restoring division of 400*coord by z, offset and clamp to 16 bits
   function automatic logic [15:0] pixel_of(longint coord, longint z, longint off,
                                            inout bit sat);
      longint num, low_z, high_z, rem;
      logic [15:0] q;
      num = coord * 400;
      low_z = (-32768 - off) * z;
      high_z = (32768 - off) * z;
      q = '0;
      if (num < low_z) begin
         sat = 1;
         return 16'h8000;
      end
      if (num >= high_z) begin
         sat = 1;
         return 16'h7FFF;
      end
      rem = num - low_z;
      for (int b = 15; b >= 0; b--) begin
         if (rem >= (z <<< b)) begin
            rem = rem - (z <<< b);
            q[b] = 1'b1;
         end
      end
      return q ^ 16'h8000;
   endfunction

   function automatic projection_type project_vertex(vertex_type v);
      longint sx, cx, sy, cy, sz, cz, acc, z;
      longint m[3][3];
      longint d[3], cen[3];
      logic [31:0] rot[3];
      projection_type p;
      bit sat;
      sx = sine_fixed(angle_x); cx = sine_fixed(angle_x + 90);
      sy = sine_fixed(angle_y); cy = sine_fixed(angle_y + 90);
      sz = sine_fixed(angle_z); cz = sine_fixed(angle_z + 90);
      cen[0] = centre_x; cen[1] = centre_y; cen[2] = centre_z;
      d[0] = longint'(signed'(v.x)) - centre_x;
      d[1] = longint'(signed'(v.y)) - centre_y;
      d[2] = longint'(signed'(v.z)) - centre_z;
      m[0][0] = trig_mul(cy, cz);
      m[0][1] = trig_mul(trig_mul(sx, sy), cz) - trig_mul(cx, sz);
      m[0][2] = trig_mul(sx, sz) + trig_mul(trig_mul(cx, sy), cz);
      m[1][0] = trig_mul(cy, sz);
      m[1][1] = trig_mul(cx, cz) + trig_mul(trig_mul(sx, sy), sz);
      m[1][2] = trig_mul(trig_mul(cx, sy), sz) - trig_mul(sx, cz);
      m[2][0] = -sy;
      m[2][1] = trig_mul(sx, cy);
      m[2][2] = trig_mul(cx, cy);
      for (int r = 0; r < 3; r++) begin
         acc = 64'sd1 <<< (FRAC - 1);
         for (int c = 0; c < 3; c++) acc += d[c] * m[r][c];
         acc = (acc >>> FRAC) + cen[r];
         rot[r] = acc[31:0];
      end
      p.rot_x = rot[0];
      p.rot_y = rot[1];
      p.rot_z = rot[2];
      z = longint'(signed'(rot[2]));
      sat = 0;
      if (z <= 0) begin
         p.pix_x = '0;
         p.pix_y = '0;
         p.behind = 1'b1;
         p.sat = 1'b0;
      end else begin
         p.pix_x = pixel_of(longint'(signed'(rot[0])), z, 400, sat);
         p.pix_y = pixel_of(longint'(signed'(rot[1])), z, 300, sat);
         p.behind = 1'b0;
         p.sat = sat;
      end
      return p;
   endfunction

   task automatic write_reg(logic [erpp_pkg::CSR_ADDR_W-1:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      case (idx)
         erpp_pkg::REG_ANGLE_X:  angle_x = value[8:0];
         erpp_pkg::REG_ANGLE_Y:  angle_y = value[8:0];
         erpp_pkg::REG_ANGLE_Z:  angle_z = value[8:0];
         erpp_pkg::REG_CENTER_X: centre_x = longint'(signed'(value));
         erpp_pkg::REG_CENTER_Y: centre_y = longint'(signed'(value));
         erpp_pkg::REG_CENTER_Z: centre_z = longint'(signed'(value));
         default: ;
      endcase
   endtask

   task automatic end_writes();
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // hold until the last vertex has left the driver and every result is back
   task automatic drain();
      wait (pending_vertices.size() == 0 && expected_projections.size() == 0 && !req_tvalid);
   endtask

   function automatic vertex_type vtx(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      vertex_type v;
      v.x = x; v.y = y; v.z = z;
      return v;
   endfunction

   function automatic void add_vertex(vertex_type v);
      pending_vertices.insert(pending_vertices.size(), v);
   endfunction

   // mostly scene-sized coordinates in front of the camera, some full-range noise
   function automatic vertex_type random_vertex();
      int kind;
      kind = $urandom_range(99);
      if (kind < 70)
         return vtx($urandom_range(0, 32'h01000000) - 32'h00800000,
                    $urandom_range(0, 32'h01000000) - 32'h00800000,
                    $urandom_range(32'h00001000, 32'h00C00000));
      else if (kind < 85)
         return vtx($urandom_range(0, 32'h00100000) - 32'h00080000,
                    $urandom_range(0, 32'h00100000) - 32'h00080000,
                    $urandom_range(1, 32'h00000800));
      return vtx($urandom, $urandom, $urandom);
   endfunction

   function automatic logic [31:0] random_centre();
      case ($urandom_range(3))
         0: return '0;
         1: return $urandom;
         default: return $urandom_range(0, 32'h00400000) - 32'h00200000;
      endcase
   endfunction

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_projections.insert(expected_projections.size(), project_vertex(
               vtx(req_tdata[31:0], req_tdata[63:32], req_tdata[95:64])));
         if (!(req_tvalid && !req_tready)) begin
            if (pending_vertices.size() > 0 && $urandom_range(99) >= idle_pct) begin
               vertex_type v;
               v = pending_vertices.pop_front();
               req_tdata <= {v.z, v.y, v.x};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         failures++;
      end
   endtask

   // receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= idle_pct);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_projections.size() == 0) begin
               $error("rsp transaction with no vertex outstanding");
               failures++;
            end else begin
               projection_type e;
               e = expected_projections.pop_front();
               check_field("rotated_x", e.rot_x, rsp_tdata[31:0]);
               check_field("rotated_y", e.rot_y, rsp_tdata[63:32]);
               check_field("rotated_z", e.rot_z, rsp_tdata[95:64]);
               check_field("screen_x", e.pix_x, rsp_tdata[111:96]);
               check_field("screen_y", e.pix_y, rsp_tdata[127:112]);
               check_field("behind_camera", e.behind, rsp_tuser[0]);
               check_field("pixel_saturated", e.sat, rsp_tuser[1]);
            end
         end
      end
   end

   // watchdog on cycles without progress
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (pending_vertices.size() == 0 && expected_projections.size() == 0))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("** euler_rotate_perspective_project: FAILED **");
         $finish;
      end
   end

   initial begin
      logic [31:0] angle_set[7];
      angle_set = '{0, 90, 180, 270, 359, 360, 511};
      angle_x = 0; angle_y = 0; angle_z = 0;
      centre_x = 0; centre_y = 0; centre_z = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // identity rotation: projection corner cases
      add_vertex(vtx(0, 0, 0));
      add_vertex(vtx(0, 0, 32'h00010000));
      add_vertex(vtx(32'h00010000, 32'hFFFF0000, 32'h00020000));
      add_vertex(vtx(32'h7FFFFFFF, 0, 1));
      add_vertex(vtx(32'h80000000, 0, 1));
      add_vertex(vtx(0, 32'h7FFFFFFF, 1));
      add_vertex(vtx(0, 32'h80000000, 1));
      add_vertex(vtx(32'h00050000, 32'h00050000, 32'hFFFF0000));
      add_vertex(vtx(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
      add_vertex(vtx(32'h80000000, 32'h80000000, 32'h80000000));
      add_vertex(vtx(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
      add_vertex(vtx(32'h00520000, 32'h003D0000, 32'h00010000));
      drain();

      // out-of-range indexes are dropped, then extreme centres with rotation
      write_reg(REG_SPARE_LO, 32'h12345678);
      write_reg(REG_SPARE_HI, 32'hFFFFFFFF);
      write_reg(erpp_pkg::REG_ANGLE_X, 32'hFFFFFE5A);  // 90 with junk above bit 8
      write_reg(erpp_pkg::REG_ANGLE_Y, 359);
      write_reg(erpp_pkg::REG_ANGLE_Z, 511);
      write_reg(erpp_pkg::REG_CENTER_X, 32'h7FFFFFFF);
      write_reg(erpp_pkg::REG_CENTER_Y, 32'h80000000);
      write_reg(erpp_pkg::REG_CENTER_Z, 32'h80000000);
      end_writes();
      add_vertex(vtx(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF));
      add_vertex(vtx(32'h7FFFFFFF, 32'h80000000, 32'h80000000));
      add_vertex(vtx(0, 0, 0));
      for (int i = 0; i < 5; i++) add_vertex(random_vertex());
      drain();

      for (int phase = 0; phase < 12; phase++) begin
         if (phase < 7) begin
            write_reg(erpp_pkg::REG_ANGLE_X, angle_set[phase]);
            write_reg(erpp_pkg::REG_ANGLE_Y, angle_set[(phase + 3) % 7]);
            write_reg(erpp_pkg::REG_ANGLE_Z, angle_set[(phase + 5) % 7]);
         end else begin
            write_reg(erpp_pkg::REG_ANGLE_X, $urandom);
            write_reg(erpp_pkg::REG_ANGLE_Y, $urandom_range(359));
            write_reg(erpp_pkg::REG_ANGLE_Z, $urandom_range(511));
         end
         write_reg(erpp_pkg::REG_CENTER_X, random_centre());
         write_reg(erpp_pkg::REG_CENTER_Y, random_centre());
         write_reg(erpp_pkg::REG_CENTER_Z, (phase % 3 == 0) ? 32'h0 : random_centre());
         end_writes();
         // hold both sides busy for one whole phase
         idle_pct = (phase == 4) ? 0 : 12;
         for (int i = 0; i < 45; i++) add_vertex(random_vertex());
         drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("** euler_rotate_perspective_project: PASSED **");
      else
         $display("** euler_rotate_perspective_project: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire
